### rtl/vcc_pkg.sv
// Package for the valid-mode 2D cross-correlation block.
// Shared constants and types; no dependencies.
`default_nettype none
package vcc_pkg;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_KERNEL_DEF = 8;
    localparam int SUM_W          = 38;
    localparam int VAL_W          = 16;
    localparam int POS_W          = 6;
    localparam int IW_W           = 7;
    localparam int KS_W           = 4;
    localparam logic MODE_KERNEL  = 1'b0;
    localparam logic MODE_PIXEL   = 1'b1;
    localparam logic REG_WIDTH    = 1'b0;
    localparam logic REG_KSIZE    = 1'b1;

    // Control from sequencer to MAC.
    typedef struct packed {
        logic clear;
        logic acc_en;
    } mac_ctl_t;
endpackage
`default_nettype wire

### rtl/valid_conv2d_cross_correlation.sv
// Valid-mode 2D cross-correlation: kernel taps and image pixels share one
// input stream (tuser = mode). Each pixel is written to a row buffer; if it
// closes a window that lies wholly inside the image, a sequencer walks the
// f*f taps through one shared multiply-accumulate, one tap per cycle, and
// then presents a result beat. Kernel beats and pixels that close no window
// are taken back to back; after a pixel that closes one, the tap walk, the
// drain of the read and MAC pipeline and the result beat come before the
// next accept, which waits until the result beat is taken. This is set by
// the single MAC and the single read port of each buffer. The block holds
// s_tready low while a window is computed or a result beat waits.
// Writing a register restarts the image; writing kernel_size also restarts
// the kernel load. Unloaded kernel entries and unwritten row entries read as
// undefined. Depends on vcc_pkg and vcc_mac.
`default_nettype none
module valid_conv2d_cross_correlation #(
    parameter int MAX_WIDTH  = vcc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = vcc_pkg::MAX_KERNEL_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] value
    input  wire logic        s_tuser,   // [0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [5:0] out_row, [11:6] out_col, [49:12] sum
    output logic             m_tlast    // last
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int NW  = $clog2(MAX_WIDTH + 1);
    localparam int FW  = $clog2(MAX_KERNEL + 1);
    localparam int KIW = $clog2(MAX_KERNEL*MAX_KERNEL + 1);
    localparam int RD  = MAX_WIDTH * MAX_KERNEL;
    localparam int RAW = $clog2(RD);
    localparam int KD  = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW = (KD > 1) ? $clog2(KD) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [vcc_pkg::IW_W-1:0] iw_reg;
    logic [vcc_pkg::KS_W-1:0] ks_reg;
    logic [CW-1:0]  prow_reg, pcol_reg;
    logic [KIW-1:0] kidx_reg;
    logic [FW-1:0]  ti_reg, tj_reg;
    logic [1:0]     tail_reg;
    logic [CW-1:0]  r0_reg, c0_reg;
    logic           last_reg;
    logic signed [vcc_pkg::VAL_W-1:0] row_mem [RD];
    logic signed [vcc_pkg::VAL_W-1:0] ker_mem [KD];
    logic signed [vcc_pkg::VAL_W-1:0] pix_q, ker_q;
    logic        rd_vld_reg;
    logic [vcc_pkg::SUM_W-1:0] sum_reg;
    vcc_pkg::mac_ctl_t mac_ctl;
    logic signed [vcc_pkg::SUM_W-1:0] sat_sum;

    // effective sizes after clamping
    logic [NW-1:0] n_eff;
    logic [FW-1:0] f_eff;
    always_comb
    begin
        if (iw_reg == '0)
            n_eff = NW'(1);
        else if (32'(iw_reg) > MAX_WIDTH)
            n_eff = NW'(MAX_WIDTH);
        else
            n_eff = NW'(iw_reg);
        if (ks_reg == '0)
            f_eff = FW'(1);
        else if (32'(ks_reg) > MAX_KERNEL)
            f_eff = FW'(MAX_KERNEL);
        else
            f_eff = FW'(ks_reg);
    end

    logic [KIW-1:0] ff;
    assign ff = KIW'(f_eff * f_eff);

    logic in_acc;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // position of this pixel, with wrap if register change shrank the image
    logic          oob;
    logic [CW-1:0] r, c;
    assign oob = ({1'b0, prow_reg} >= (CW+1)'(n_eff)) || ({1'b0, pcol_reg} >= (CW+1)'(n_eff));
    assign r   = oob ? '0 : prow_reg;
    assign c   = oob ? '0 : pcol_reg;

    logic emit;
    assign emit = ((NW+1)'(f_eff) <= (NW+1)'(n_eff)) && ((CW+1)'(r) + 1'b1 >= (CW+1)'(f_eff))
                  && ((CW+1)'(c) + 1'b1 >= (CW+1)'(f_eff));

    logic [KIW-1:0] kwr;
    assign kwr = (kidx_reg >= ff) ? '0 : kidx_reg;

    // read addresses for the current tap
    logic [CW+FW-1:0] rrow, rcol;
    logic [RAW-1:0]   raddr;
    logic [KAW-1:0]   kaddr;
    assign rrow  = (CW+FW)'(r0_reg) + (CW+FW)'(ti_reg);
    assign rcol  = (CW+FW)'(c0_reg) + (CW+FW)'(tj_reg);
    assign raddr = RAW'((rrow % MAX_KERNEL) * MAX_WIDTH + rcol);
    assign kaddr = KAW'(ti_reg * f_eff + tj_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc && s_tuser == vcc_pkg::MODE_PIXEL)
            row_mem[RAW'((r % MAX_KERNEL) * MAX_WIDTH + c)] <= s_tdata;
        if (in_acc && s_tuser == vcc_pkg::MODE_KERNEL)
            ker_mem[KAW'(kwr)] <= s_tdata;
        pix_q <= row_mem[raddr];
        ker_q <= ker_mem[kaddr];
    end

    logic last_tap;
    assign last_tap = (ti_reg == f_eff - 1'b1) && (tj_reg == f_eff - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        mac_ctl.clear   = 1'b0;
        mac_ctl.acc_en  = rd_vld_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && s_tuser == vcc_pkg::MODE_PIXEL && emit)
                    state_next = S_RUN;
            S_RUN:
            begin
                if (ti_reg == '0 && tj_reg == '0)
                    mac_ctl.clear = 1'b1;
                if (last_tap)
                    state_next = S_TAIL;
            end
            S_TAIL:
                if (tail_reg == 2'd2)
                    state_next = S_OUT;
            S_OUT:
                if (m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iw_reg     <= vcc_pkg::IW_W'(8);
            ks_reg     <= vcc_pkg::KS_W'(3);
            prow_reg   <= '0;
            pcol_reg   <= '0;
            kidx_reg   <= '0;
            ti_reg     <= '0;
            tj_reg     <= '0;
            tail_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_RUN);
            if (cfg_we)
            begin
                prow_reg <= '0;
                pcol_reg <= '0;
                if (cfg_index == vcc_pkg::REG_WIDTH)
                    iw_reg <= cfg_data;
                else
                begin
                    ks_reg   <= cfg_data[vcc_pkg::KS_W-1:0];
                    kidx_reg <= '0;
                end
            end
            else if (in_acc && s_tuser == vcc_pkg::MODE_KERNEL)
                kidx_reg <= (kwr + 1'b1 >= ff) ? '0 : kwr + 1'b1;
            else if (in_acc)
            begin
                if ((CW+1)'(c) + 1'b1 >= (CW+1)'(n_eff))
                begin
                    pcol_reg <= '0;
                    prow_reg <= ((CW+1)'(r) + 1'b1 >= (CW+1)'(n_eff)) ? '0 : r + 1'b1;
                end
                else
                begin
                    pcol_reg <= c + 1'b1;
                    prow_reg <= r;
                end
            end
            if (state_reg == S_RUN)
            begin
                if (tj_reg == f_eff - 1'b1)
                begin
                    tj_reg <= '0;
                    ti_reg <= last_tap ? '0 : ti_reg + 1'b1;
                end
                else
                    tj_reg <= tj_reg + 1'b1;
            end
            tail_reg <= (state_reg == S_TAIL) ? tail_reg + 1'b1 : '0;
        end
    end

    // window origin and last flag captured at the accepting pixel
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            r0_reg   <= r + 1'b1 - CW'(f_eff);
            c0_reg   <= c + 1'b1 - CW'(f_eff);
            last_reg <= ((NW)'(r) == n_eff - 1'b1) && ((NW)'(c) == n_eff - 1'b1);
        end
        if (state_reg == S_TAIL && tail_reg == 2'd2)
            sum_reg <= sat_sum;
    end

    vcc_mac u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .a       (pix_q),
        .b       (ker_q),
        .sat_sum (sat_sum)
    );

    logic [5:0] orow, ocol;
    assign orow     = 6'(r0_reg);
    assign ocol     = 6'(c0_reg);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, sum_reg, ocol, orow};
    assign m_tlast  = last_reg;
endmodule
`default_nettype wire

### rtl/vcc_mac.sv
// Shared multiply-accumulate unit with output saturation.
// Depends on vcc_pkg.
`default_nettype none
module vcc_mac (
    input  wire logic                        clk,
    input  wire vcc_pkg::mac_ctl_t           ctl,
    input  wire logic signed [vcc_pkg::VAL_W-1:0] a,
    input  wire logic signed [vcc_pkg::VAL_W-1:0] b,
    output logic signed [vcc_pkg::SUM_W-1:0] sat_sum
);
    localparam int ACC_W = 48;
    logic signed [2*vcc_pkg::VAL_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic signed [ACC_W-1:0]            acc_next;
    logic                               acc_en_reg;
    localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) <<< (vcc_pkg::SUM_W-1)) - 1;
    localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1) <<< (vcc_pkg::SUM_W-1));

    // product registered, then summed next cycle
    always_ff @(posedge clk)
    begin
        prod_reg   <= a * b;
        acc_en_reg <= ctl.acc_en;
        acc_reg    <= acc_next;
    end

    always_comb
    begin
        acc_next = ctl.clear ? '0 : acc_reg;
        if (acc_en_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        if (acc_reg > SMAX)
            sat_sum = SMAX[vcc_pkg::SUM_W-1:0];
        else if (acc_reg < SMIN)
            sat_sum = SMIN[vcc_pkg::SUM_W-1:0];
        else
            sat_sum = acc_reg[vcc_pkg::SUM_W-1:0];
    end
endmodule
`default_nettype wire

### rtl/vcc_checker.sv
// Port-level checker for valid_conv2d_cross_correlation, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module vcc_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tlast
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input open during result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[55:50] == 6'd0) else $error("pad bits set");
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> s_tready) else $error("no return to ready");
endmodule

bind valid_conv2d_cross_correlation vcc_port_checker u_vcc_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
